[hdl/erq_pkg.sv]
// ----------------------------------------------------------------------------
// erq_pkg
// Shared constants, word types, action codes and handshake structs for the
// event ring queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int EVENT_BITS  = 64;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ACT_ENQUEUE  = 3'd0;
    localparam logic [2:0] ACT_DEQUEUE  = 3'd1;
    localparam logic [2:0] ACT_PEEK     = 3'd2;
    localparam logic [2:0] ACT_PEEK_SEV = 3'd3;
    localparam logic [2:0] ACT_DROP     = 3'd4;
    localparam logic [2:0] ACT_GET_SEV  = 3'd5;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] event_word;
        logic [7:0]  amount;
    } t_in_word;

    typedef struct packed {
        logic        ok;
        logic [63:0] out_event;
        logic [6:0]  handled;
        logic        last;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic do_single;
        logic do_step;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_read;
        logic out_free;
        logic last;
    } t_status;

    // Ring pointer advance; pos + step stays below twice the depth.
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] pos,
                                                  input logic [CNT_W-1:0] step);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(pos) + (CNT_W + 1)'(step);
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

[hdl/erq_ctrl.sv]
// ----------------------------------------------------------------------------
// erq_ctrl
// Sequencer for the event ring queue: accept a word, then either finish it
// with one result or walk the slot memory one event at a time, each through a
// slot read (EXEC) and a step (FETCH) that waits for a free output register.
`timescale 1ns / 1ps

module erq_ctrl
    import erq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // slot read at the walk position is issued in this cycle
                if (i_status.is_read) begin
                    n_state = ST_FETCH;
                end else if (i_status.out_free) begin
                    o_cmd.do_single = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_FETCH: begin
                if (i_status.out_free) begin
                    o_cmd.do_step = 1'b1;
                    n_state       = i_status.last ? ST_IDLE : ST_EXEC;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/erq_datapath.sv]
// ----------------------------------------------------------------------------
// erq_datapath
// Slot memory, ring pointers, fill level, captured word and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erq_datapath
    import erq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    logic [EVENT_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [EVENT_BITS-1:0] r_rdata;

    logic [2:0]            r_act;
    logic [EVENT_BITS-1:0] r_word;
    logic [CNT_W-1:0]      r_n;
    logic [CNT_W-1:0]      r_idx;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [CNT_W-1:0]      r_fill;
    t_out_word             r_out;
    logic                  r_out_valid;

    logic [CNT_W-1:0]      n_n;
    logic [CNT_W-1:0]      idx_inc;
    logic [PTR_W-1:0]      rd_addr;
    logic                  full;
    logic                  read_act;
    logic                  remove;
    logic                  load;

    assign full     = (r_fill == CNT_W'(QUEUE_DEPTH));
    assign read_act = (r_act == ACT_DEQUEUE) || (r_act == ACT_PEEK)
                   || (r_act == ACT_PEEK_SEV) || (r_act == ACT_GET_SEV);
    assign remove   = (r_act == ACT_DEQUEUE) || (r_act == ACT_GET_SEV);
    assign idx_inc  = r_idx + 1'b1;
    assign rd_addr  = ring_add(r_rd_ptr, r_idx);
    assign load     = i_cmd.do_single || i_cmd.do_step;

    // events to emit or drop: single reads take one if any is there
    always_comb begin
        if ((i_in_word.action == ACT_DEQUEUE) || (i_in_word.action == ACT_PEEK)) begin
            n_n = (r_fill != '0) ? CNT_W'(1) : '0;
        end else if (i_in_word.amount < 8'(r_fill)) begin
            n_n = i_in_word.amount[CNT_W-1:0];
        end else begin
            n_n = r_fill;
        end
    end

    assign o_status.is_read  = read_act && (r_n != '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.last     = (idx_inc == r_n);

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (i_cmd.do_single && (r_act == ACT_ENQUEUE) && !full) begin
            r_mem[r_wr_ptr] <= r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= i_in_word.action;
            r_word <= i_in_word.event_word[EVENT_BITS-1:0];
            r_n    <= n_n;
            r_idx  <= '0;
        end else if (i_cmd.do_step) begin
            r_idx <= idx_inc;
        end
        if (load) begin
            if (i_cmd.do_step) begin
                r_out.ok        <= 1'b1;
                r_out.out_event <= 64'(r_rdata);
                r_out.handled   <= 7'(idx_inc);
                r_out.last      <= o_status.last;
            end else begin
                r_out.out_event <= '0;
                r_out.last      <= 1'b1;
                case (r_act)
                    ACT_ENQUEUE: begin
                        r_out.ok      <= !full;
                        r_out.handled <= full ? 7'd0 : 7'd1;
                    end
                    ACT_DROP: begin
                        r_out.ok      <= (r_n != '0);
                        r_out.handled <= 7'(r_n);
                    end
                    default: begin
                        r_out.ok      <= 1'b0;
                        r_out.handled <= '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.do_single && (r_act == ACT_ENQUEUE) && !full) begin
                r_wr_ptr <= ring_add(r_wr_ptr, CNT_W'(1));
                r_fill   <= r_fill + 1'b1;
            end else if (i_cmd.do_single && (r_act == ACT_DROP)) begin
                r_rd_ptr <= ring_add(r_rd_ptr, r_n);
                r_fill   <= r_fill - r_n;
            end else if (i_cmd.do_step && o_status.last && remove) begin
                r_rd_ptr <= ring_add(r_rd_ptr, r_n);
                r_fill   <= r_fill - r_n;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

[hdl/event_ring_queue_top.sv]
// ----------------------------------------------------------------------------
// event_ring_queue_top
// Flow: a single result is loaded into the output register from EXEC; a read
//   walk issues a registered slot read in EXEC and loads the event in FETCH.
// Handshake: one word at a time; a read of n events walks EXEC and FETCH
//   once per event (one registered slot read per event).
//   Output stalls hold the sequencer until the output register is free.
// Reset: synchronous active low; clears pointers, fill level, sequencer and
//   output valid. Slot contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module event_ring_queue_top
    import erq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // Command and status between the sequencer and the datapath
    t_cmd    cmd;
    t_status status;

    // Sequencer: accept a word, finish it in one step or walk the slots
    erq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: slot memory, ring state and the output register that
    // decouples a waiting result from the input side
    erq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

[hdl/erq_checker.sv]
// ----------------------------------------------------------------------------
// erq_checker
// Port-level checks for the event ring queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erq_checker
    import erq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed");

    // one word at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted a word while busy");

    // failed results carry no event
    a_fail_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.ok |-> (o_out_word.out_event == '0))
        else $error("failed result carries an event");

    // only a successful walk result may be non-final
    a_nonlast_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last |-> o_out_word.ok && (o_out_word.handled != '0))
        else $error("non-final result without a handled event");

endmodule

bind event_ring_queue_top erq_checker u_erq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
